[design/imuq_pkg.sv]
// imuq_pkg: shared types, codes and constants of the imu sample qualifier
// no dependencies; compile before every other file of the block

package imuq_pkg;

  localparam int unsigned IMU_COUNT_DEF   = 2;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [7:0]  STATUS_DEAD = 8'hFF;
  localparam logic [7:0]  READY_MASK  = 8'h03;
  localparam logic [7:0]  COUNT_MAX   = 8'd255;
  localparam logic [15:0] PREV_RESET  = 16'h7FFF;

  localparam logic [7:0]  FROZEN_LIMIT_RST = 8'd10;
  localparam logic [23:0] ACCEL_GAIN_RST   = 24'd2047;
  localparam logic [23:0] GYRO_GAIN_RST    = 24'd20497;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FROZEN_LIMIT = 2'd0,
    CFG_ACCEL_GAIN   = 2'd1,
    CFG_GYRO_GAIN    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FAULT_OK        = 3'd0,
    FAULT_DEAD      = 3'd1,
    FAULT_NOT_READY = 3'd2,
    FAULT_FROZEN    = 3'd3,
    FAULT_CLEARED   = 3'd4
  } fault_e;

  typedef struct packed {
    logic              kind;
    logic              imu_select;
    logic [7:0]        first_status;
    logic [7:0]        retry_status;
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] gyro_z_raw;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
  } in_item_t;

  typedef struct packed {
    logic               sample_valid;
    fault_e             fault;
    logic signed [31:0] accel_x_scaled;
    logic signed [31:0] accel_y_scaled;
    logic signed [31:0] accel_z_scaled;
    logic signed [31:0] rate_x_scaled;
    logic signed [31:0] rate_y_scaled;
    logic signed [31:0] rate_z_scaled;
  } out_item_t;

  // one classified beat between front and back
  typedef struct packed {
    logic               ok;
    fault_e             fault;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } q_entry_t;

  typedef struct packed {
    logic [7:0]  frozen_limit;
    logic [23:0] accel_gain;
    logic [23:0] gyro_gain;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[design/imuq_in_if.sv]
// imuq_in_if: valid/ready channel carrying one input beat
// depends on imuq_pkg

interface imuq_in_if;
  import imuq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[design/imuq_out_if.sv]
// imuq_out_if: valid/ready channel carrying one result beat
// depends on imuq_pkg

interface imuq_out_if;
  import imuq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[design/imuq_front.sv]
// imuq_front: accepts input beats, classifies status and tracks frozen gyro triples
// depends on imuq_pkg and imuq_in_if; pushes classified beats into imuq_fifo

module imuq_front #(
  parameter int unsigned IMU_COUNT = imuq_pkg::IMU_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  imuq_in_if.sink             in_i,
  input  logic [7:0]          frozen_limit_i,
  input  logic                full_i,
  output logic                push_o,
  output imuq_pkg::q_entry_t  push_data_o
);
  import imuq_pkg::*;

  localparam int unsigned IDX_W = (IMU_COUNT > 1) ? $clog2(IMU_COUNT) : 1;

  logic [15:0] prev_x_q [IMU_COUNT];
  logic [15:0] prev_y_q [IMU_COUNT];
  logic [15:0] prev_z_q [IMU_COUNT];
  logic [7:0]  cnt_q    [IMU_COUNT];
  logic [15:0] prev_x_d [IMU_COUNT];
  logic [15:0] prev_y_d [IMU_COUNT];
  logic [15:0] prev_z_d [IMU_COUNT];
  logic [7:0]  cnt_d    [IMU_COUNT];

  logic [IDX_W-1:0] idx;
  logic             accept;
  fault_e           status_fault;
  fault_e           fault;
  logic             same;
  logic [7:0]       cnt_inc;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign idx        = (IMU_COUNT == 1) ? '0 : IDX_W'(in_i.item.imu_select);

  always_comb begin
    status_fault = FAULT_OK;
    if (in_i.item.first_status == STATUS_DEAD) begin
      status_fault = FAULT_DEAD;
    end else if ((in_i.item.first_status & READY_MASK) != READY_MASK) begin
      if (in_i.item.retry_status == STATUS_DEAD) begin
        status_fault = FAULT_DEAD;
      end else if ((in_i.item.retry_status & READY_MASK) != READY_MASK) begin
        status_fault = FAULT_NOT_READY;
      end
    end
  end

  assign same = (in_i.item.gyro_x_raw == prev_x_q[idx]) &&
                (in_i.item.gyro_y_raw == prev_y_q[idx]) &&
                (in_i.item.gyro_z_raw == prev_z_q[idx]);
  assign cnt_inc = (cnt_q[idx] == COUNT_MAX) ? cnt_q[idx] : cnt_q[idx] + 8'd1;

  always_comb begin
    if (in_i.item.kind) begin
      fault = FAULT_CLEARED;
    end else if (status_fault != FAULT_OK) begin
      fault = status_fault;
    end else if (same && (cnt_inc >= frozen_limit_i)) begin
      fault = FAULT_FROZEN;
    end else begin
      fault = FAULT_OK;
    end
  end

  // tracker update for the selected imu
  always_comb begin
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    prev_z_d = prev_z_q;
    cnt_d    = cnt_q;
    if (accept) begin
      if (in_i.item.kind) begin
        prev_x_d[idx] = PREV_RESET;
        prev_y_d[idx] = PREV_RESET;
        prev_z_d[idx] = PREV_RESET;
        cnt_d[idx]    = '0;
      end else if (status_fault == FAULT_OK) begin
        if (same) begin
          cnt_d[idx] = cnt_inc;
        end else begin
          prev_x_d[idx] = in_i.item.gyro_x_raw;
          prev_y_d[idx] = in_i.item.gyro_y_raw;
          prev_z_d[idx] = in_i.item.gyro_z_raw;
          cnt_d[idx]    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < IMU_COUNT; i++) begin
        prev_x_q[i] <= PREV_RESET;
        prev_y_q[i] <= PREV_RESET;
        prev_z_q[i] <= PREV_RESET;
        cnt_q[i]    <= '0;
      end
    end else begin
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      prev_z_q <= prev_z_d;
      cnt_q    <= cnt_d;
    end
  end

  assign push_o              = accept;
  assign push_data_o.ok      = (fault == FAULT_OK);
  assign push_data_o.fault   = fault;
  assign push_data_o.accel_x = in_i.item.accel_x_raw;
  assign push_data_o.accel_y = in_i.item.accel_y_raw;
  assign push_data_o.accel_z = in_i.item.accel_z_raw;
  assign push_data_o.gyro_x  = in_i.item.gyro_x_raw;
  assign push_data_o.gyro_y  = in_i.item.gyro_y_raw;
  assign push_data_o.gyro_z  = in_i.item.gyro_z_raw;

endmodule

[design/imuq_fifo.sv]
// imuq_fifo: short queue of classified beats between front and back
// depends on imuq_pkg

module imuq_fifo #(
  parameter int unsigned DEPTH = imuq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  imuq_pkg::q_entry_t push_data_i,
  input  logic               pop_i,
  output imuq_pkg::q_entry_t pop_data_o,
  output imuq_pkg::qstat_t   stat_o
);
  import imuq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == FULL_CNT);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/imuq_back.sv]
// imuq_back: two-stage scaler, multiply then round into the output register
// depends on imuq_pkg and imuq_out_if; pops classified beats from imuq_fifo

module imuq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imuq_pkg::q_entry_t q_data_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  input  logic [23:0]        accel_gain_i,
  input  logic [23:0]        gyro_gain_i,
  imuq_out_if.source         out_o
);
  import imuq_pkg::*;

  typedef struct packed {
    logic        ok;
    fault_e      fault;
    logic [40:0] ax;
    logic [40:0] ay;
    logic [40:0] az;
    logic [40:0] gx;
    logic [40:0] gy;
    logic [40:0] gz;
  } prod_t;

  // 16 x 25 signed product, gain zero-extended
  function automatic logic [40:0] mul(input logic signed [15:0] raw,
                                      input logic [23:0] gain);
    logic signed [24:0] g;
    logic signed [40:0] p;
    g = $signed({1'b0, gain});
    p = raw * g;
    return p;
  endfunction

  // round to nearest, ties up, then drop the 8 extra fraction bits
  function automatic logic signed [31:0] rnd(input logic [40:0] p);
    logic [40:0] s;
    s = p + 41'd128;
    return s[39:8];
  endfunction

  logic      s1_valid_q, s1_valid_d;
  logic      s2_valid_q, s2_valid_d;
  prod_t     s1_q, s1_d;
  out_item_t s2_q, s2_d;
  logic      adv, s1_ld;

  assign adv   = !s2_valid_q || out_o.ready;
  assign s1_ld = !s1_valid_q || adv;
  assign pop_o = s1_ld && !q_empty_i;

  always_comb begin
    s1_d.ok    = q_data_i.ok;
    s1_d.fault = q_data_i.fault;
    s1_d.ax    = mul(q_data_i.accel_x, accel_gain_i);
    s1_d.ay    = mul(q_data_i.accel_y, accel_gain_i);
    s1_d.az    = mul(q_data_i.accel_z, accel_gain_i);
    s1_d.gx    = mul(q_data_i.gyro_x, gyro_gain_i);
    s1_d.gy    = mul(q_data_i.gyro_y, gyro_gain_i);
    s1_d.gz    = mul(q_data_i.gyro_z, gyro_gain_i);
  end

  always_comb begin
    s2_d = '0;
    s2_d.fault = s1_q.fault;
    if (s1_q.ok) begin
      s2_d.sample_valid   = 1'b1;
      s2_d.accel_x_scaled = rnd(s1_q.ax);
      s2_d.accel_y_scaled = rnd(s1_q.ay);
      s2_d.accel_z_scaled = rnd(s1_q.az);
      s2_d.rate_x_scaled  = rnd(s1_q.gx);
      s2_d.rate_y_scaled  = rnd(s1_q.gy);
      s2_d.rate_z_scaled  = rnd(s1_q.gz);
    end
  end

  assign s1_valid_d = s1_ld ? !q_empty_i : s1_valid_q;
  assign s2_valid_d = adv ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= s1_d;
    end
    if (adv && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_o.valid = s2_valid_q;
  assign out_o.item  = s2_q;

endmodule

[design/imu_sample_qualifier.sv]
// imu_sample_qualifier: top level, configuration registers and the front, queue and back
// depends on imuq_pkg, imuq_in_if, imuq_out_if, imuq_front, imuq_fifo and imuq_back

// One beat in, one beat out: a sample beat is checked for dead bus and data-ready
// status, its gyro triple is compared with the last one stored for that imu, and
// if it passes, the accel and gyro axes are scaled to signed Q15.16. A clear beat
// resets that imu's tracker and returns fault 4. The block takes one beat per
// cycle while the queue is not full; the frozen tracker sits in the front and is
// updated at the accepting edge, so back-to-back samples of the same imu see each
// other. A result passes the queue, written at the accepting edge, then the stage
// register of the six 16x24 multipliers and the rounding output register. The queue
// holds up to QUEUE_DEPTH beats, so the input keeps flowing while the output is
// stalled until it fills. The user must write configuration through cfg_we_i,
// cfg_idx_i, cfg_wdata_i only while the block is idle; the block does not enforce it.

module imu_sample_qualifier #(
  parameter int unsigned IMU_COUNT   = imuq_pkg::IMU_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = imuq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  imuq_in_if.sink                         in_i,
  imuq_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [imuq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [imuq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import imuq_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     push, pop;
  q_entry_t push_data, pop_data;
  qstat_t   qstat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FROZEN_LIMIT: cfg_d.frozen_limit = cfg_wdata_i[7:0];
        CFG_ACCEL_GAIN:   cfg_d.accel_gain   = cfg_wdata_i[23:0];
        CFG_GYRO_GAIN:    cfg_d.gyro_gain    = cfg_wdata_i[23:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frozen_limit <= FROZEN_LIMIT_RST;
      cfg_q.accel_gain   <= ACCEL_GAIN_RST;
      cfg_q.gyro_gain    <= GYRO_GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  imuq_front #(
    .IMU_COUNT (IMU_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .frozen_limit_i (cfg_q.frozen_limit),
    .full_i         (qstat.full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  imuq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (qstat)
  );

  imuq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (pop_data),
    .q_empty_i    (qstat.empty),
    .pop_o        (pop),
    .accel_gain_i (cfg_q.accel_gain),
    .gyro_gain_i  (cfg_q.gyro_gain),
    .out_o        (out_o)
  );

`ifndef ASSERT_OFF
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("beat pushed into a full queue");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.item.sample_valid) |-> (out_o.item.fault == FAULT_OK))
    else $error("accepted sample carries a fault code");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.item.sample_valid) |->
      (out_o.item.accel_x_scaled == '0 && out_o.item.accel_y_scaled == '0 &&
       out_o.item.accel_z_scaled == '0 && out_o.item.rate_x_scaled == '0 &&
       out_o.item.rate_y_scaled == '0 && out_o.item.rate_z_scaled == '0 &&
       out_o.item.fault != FAULT_OK))
    else $error("rejected beat carries scaled values or no fault");
`endif

endmodule
